// File: hw/rtl/dihedral_angle_four_points_unit_defines.svh
// assertion macros for the dihedral angle unit
// expects clk and rst_n in the scope where a macro is used
`ifndef DIHEDRAL_ANGLE_FOUR_POINTS_UNIT_DEFINES_SVH
`define DIHEDRAL_ANGLE_FOUR_POINTS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DIHED_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DIHED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DIHED_ASSERT_SAME(lbl, ante, cons, msg)
`define DIHED_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/dihed_pkg.sv
// shared constants for the dihedral angle unit: fixed widths and the cordic
// arctangent table in units of 2^-24 degree; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dihed_pkg;

  // output field width
  localparam int TORSION_W = 16;
  // angle accumulator fraction bits (degrees)
  localparam int DEG_FRAC = 24;
  // magnitude bits kept after normalization
  localparam int NORM_BITS = 30;
  // extra fraction bits on the root of r2.r2
  localparam int ROOT_EXTRA = 16;
  localparam int HALF_TURN_DEG = 180;
  // cordic x/y width and angle accumulator width
  localparam int XW = 34;
  localparam int ZW = 35;
  localparam int ATAN_STEPS = 32;

  // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest
  localparam logic [29:0] ATAN_TAB [ATAN_STEPS] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
    30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
  };

endpackage
`default_nettype wire

// File: hw/rtl/dihedral_angle_four_points_unit.sv
// dihedral angle of four points: vectors, cross and dot products, pipelined
// square root, normalization and cordic arctangent
// depends on dihed_pkg and dihedral_angle_four_points_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "dihedral_angle_four_points_unit_defines.svh"

// Fully pipelined: one transaction may start in every clock cycle and busy
// stays low. Each transaction gives exactly one result, strobed by out_valid.
// The square root settles one root bit per stage over COORD_WIDTH+17 stages;
// it is followed by one normalization stage per shift bit and one stage per
// cordic iteration. The receiver cannot stall, so no result is ever held
// back.
module dihedral_angle_four_points_unit #(
  parameter int COORD_WIDTH     = 20,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      start,
  output logic                                     busy,
  input  wire signed [COORD_WIDTH-1:0]             in_p1_x,
  input  wire signed [COORD_WIDTH-1:0]             in_p1_y,
  input  wire signed [COORD_WIDTH-1:0]             in_p1_z,
  input  wire signed [COORD_WIDTH-1:0]             in_p2_x,
  input  wire signed [COORD_WIDTH-1:0]             in_p2_y,
  input  wire signed [COORD_WIDTH-1:0]             in_p2_z,
  input  wire signed [COORD_WIDTH-1:0]             in_p3_x,
  input  wire signed [COORD_WIDTH-1:0]             in_p3_y,
  input  wire signed [COORD_WIDTH-1:0]             in_p3_z,
  input  wire signed [COORD_WIDTH-1:0]             in_p4_x,
  input  wire signed [COORD_WIDTH-1:0]             in_p4_y,
  input  wire signed [COORD_WIDTH-1:0]             in_p4_z,
  output logic                                     out_valid,
  output logic signed [dihed_pkg::TORSION_W-1:0]   out_torsion_deg
);

  localparam int CW  = COORD_WIDTH;
  localparam int XW  = dihed_pkg::XW;
  localparam int ZW  = dihed_pkg::ZW;
  // bond vector, normal, squared length widths
  localparam int VW  = CW + 1;
  localparam int NW  = 2 * CW + 3;
  localparam int QW  = 2 * VW;
  // normal split for the dot product partial products
  localparam int H1  = NW / 2;
  localparam int HIW = NW - H1;
  localparam int P1W = H1 + 1 + VW;
  localparam int P2W = 2 * H1 + 2;
  localparam int D1W = NW + VW + 2;
  localparam int D2W = 2 * NW + 2;
  // square root
  localparam int DW  = QW + 2 * dihed_pkg::ROOT_EXTRA;
  localparam int RB  = DW / 2;
  localparam int DLY = RB - 3;
  // sine product split
  localparam int L1  = D1W / 2;
  localparam int XA  = D1W - L1;
  localparam int L2  = RB / 2;
  localparam int XB  = RB - L2;
  localparam int MPW = XA + XB + 2;
  // common width of sine and cosine terms
  localparam int SWW = D1W + RB;
  localparam int CWW = D2W + dihed_pkg::ROOT_EXTRA;
  localparam int WW  = (SWW > CWW) ? SWW : CWW;
  localparam int LVL = $clog2(WW);
  // cordic and output
  localparam int NSTEP = (CORDIC_STEPS < dihed_pkg::ATAN_STEPS) ?
                         CORDIC_STEPS : dihed_pkg::ATAN_STEPS;
  localparam int RSH = dihed_pkg::DEG_FRAC - ANGLE_FRAC_BITS;
  localparam int OW  = ANGLE_FRAC_BITS + 10;
  localparam int LAT = RB + LVL + NSTEP + 6;
  localparam logic signed [ZW-1:0] Z180 =
    ZW'(dihed_pkg::HALF_TURN_DEG) << dihed_pkg::DEG_FRAC;
  localparam logic signed [ZW-1:0] ZHALF = ZW'(1) << (RSH - 1);
  localparam logic signed [ZW-1:0] LIM_Z =
    ZW'(dihed_pkg::HALF_TURN_DEG) << ANGLE_FRAC_BITS;
  localparam logic signed [OW-1:0] LIM_O =
    OW'(dihed_pkg::HALF_TURN_DEG) << ANGLE_FRAC_BITS;

  // valid chain, one bit per stage
  logic [LAT-1:0] vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  assign out_valid = vld_r[LAT-1];

  // ---------------------------------------------------------------- stage 1
  logic signed [CW-1:0] pt [4][3];
  logic signed [VW-1:0] r1_nxt [3], r2_nxt [3], r3_nxt [3];
  logic signed [VW-1:0] r1_r [3], r2_r [3], r3_r [3];

  assign pt[0][0] = in_p1_x;
  assign pt[0][1] = in_p1_y;
  assign pt[0][2] = in_p1_z;
  assign pt[1][0] = in_p2_x;
  assign pt[1][1] = in_p2_y;
  assign pt[1][2] = in_p2_z;
  assign pt[2][0] = in_p3_x;
  assign pt[2][1] = in_p3_y;
  assign pt[2][2] = in_p3_z;
  assign pt[3][0] = in_p4_x;
  assign pt[3][1] = in_p4_y;
  assign pt[3][2] = in_p4_z;

  // bond vectors
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r1_nxt[c] = VW'(pt[1][c]) - VW'(pt[0][c]);
      r2_nxt[c] = VW'(pt[2][c]) - VW'(pt[1][c]);
      r3_nxt[c] = VW'(pt[3][c]) - VW'(pt[2][c]);
    end
  end

  always_ff @(posedge clk) begin
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
    r3_r <= r3_nxt;
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [2*VW-1:0] x1a [3], x1b [3], x2a [3], x2b [3], sq [3];
  logic signed [NW-1:0]   n1_nxt [3], n2_nxt [3];
  logic signed [NW-1:0]   n1_r [3], n2_r [3];
  logic signed [VW-1:0]   r3b_r [3];
  logic [QW-1:0]          q_nxt, q_r;

  // cross products and squared length of r2
  for (genvar c = 0; c < 3; c++) begin : g_cross
    assign x1a[c]    = r1_r[(c+1)%3] * r2_r[(c+2)%3];
    assign x1b[c]    = r1_r[(c+2)%3] * r2_r[(c+1)%3];
    assign x2a[c]    = r2_r[(c+1)%3] * r3_r[(c+2)%3];
    assign x2b[c]    = r2_r[(c+2)%3] * r3_r[(c+1)%3];
    assign sq[c]     = r2_r[c] * r2_r[c];
    assign n1_nxt[c] = NW'(x1a[c]) - NW'(x1b[c]);
    assign n2_nxt[c] = NW'(x2a[c]) - NW'(x2b[c]);
  end

  assign q_nxt = $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);

  always_ff @(posedge clk) begin
    n1_r  <= n1_nxt;
    n2_r  <= n2_nxt;
    r3b_r <= r3_r;
    q_r   <= q_nxt;
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [H1:0]    n1lo [3], n2lo [3];
  logic signed [HIW-1:0] n1hi [3], n2hi [3];
  logic signed [P1W-1:0] pa_lo_nxt [3], pa_hi_nxt [3], pa_lo_r [3], pa_hi_r [3];
  logic signed [P2W-1:0] pb_ll_nxt [3], pb_lh_nxt [3], pb_hl_nxt [3], pb_hh_nxt [3];
  logic signed [P2W-1:0] pb_ll_r [3], pb_lh_r [3], pb_hl_r [3], pb_hh_r [3];

  // partial products of n1.r3 and n1.n2
  for (genvar c = 0; c < 3; c++) begin : g_part
    assign n1lo[c]      = $signed({1'b0, n1_r[c][H1-1:0]});
    assign n2lo[c]      = $signed({1'b0, n2_r[c][H1-1:0]});
    assign n1hi[c]      = $signed(n1_r[c][NW-1:H1]);
    assign n2hi[c]      = $signed(n2_r[c][NW-1:H1]);
    assign pa_lo_nxt[c] = n1lo[c] * r3b_r[c];
    assign pa_hi_nxt[c] = n1hi[c] * r3b_r[c];
    assign pb_ll_nxt[c] = n1lo[c] * n2lo[c];
    assign pb_lh_nxt[c] = n1lo[c] * n2hi[c];
    assign pb_hl_nxt[c] = n1hi[c] * n2lo[c];
    assign pb_hh_nxt[c] = n1hi[c] * n2hi[c];
  end

  always_ff @(posedge clk) begin
    pa_lo_r <= pa_lo_nxt;
    pa_hi_r <= pa_hi_nxt;
    pb_ll_r <= pb_ll_nxt;
    pb_lh_r <= pb_lh_nxt;
    pb_hl_r <= pb_hl_nxt;
    pb_hh_r <= pb_hh_nxt;
  end

  // ---------------------------------------------------------------- stage 4
  logic signed [D1W-1:0] pr1_nxt [3], pr1_r [3];
  logic signed [D2W-1:0] pr2_nxt [3], pr2_r [3];

  // recombine partial products per component
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pr1_nxt[c] = (D1W'(pa_hi_r[c]) <<< H1) + D1W'(pa_lo_r[c]);
      pr2_nxt[c] = (D2W'(pb_hh_r[c]) <<< (2 * H1))
                 + ((D2W'(pb_hl_r[c]) + D2W'(pb_lh_r[c])) <<< H1)
                 + D2W'(pb_ll_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    pr1_r <= pr1_nxt;
    pr2_r <= pr2_nxt;
  end

  // ---------------------------------------------------------------- stage 5
  logic signed [D1W-1:0] dot1_nxt, dot1_r;
  logic signed [D2W-1:0] dot2_nxt, dot2_r;
  logic signed [D1W-1:0] dot1_dly_r [DLY];
  logic signed [D2W-1:0] dot2_dly_r [DLY];

  assign dot1_nxt = pr1_r[0] + pr1_r[1] + pr1_r[2];
  assign dot2_nxt = pr2_r[0] + pr2_r[1] + pr2_r[2];

  // dot products, then a delay line that waits for the root
  always_ff @(posedge clk) begin
    dot1_r        <= dot1_nxt;
    dot2_r        <= dot2_nxt;
    dot1_dly_r[0] <= dot1_r;
    dot2_dly_r[0] <= dot2_r;
    for (int k = 1; k < DLY; k++) begin
      dot1_dly_r[k] <= dot1_dly_r[k-1];
      dot2_dly_r[k] <= dot2_dly_r[k-1];
    end
  end

  // ------------------------------------------------------- square root pipe
  logic [DW-1:0] sq_rem_r  [RB];
  logic [RB-1:0] sq_root_r [RB];

  // restoring square root, one root bit per stage, msb first
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int B = RB - 1 - j;
    logic [DW-1:0] rem_in, rem_nxt;
    logic [RB-1:0] root_in, root_nxt;
    logic [DW:0]   delta;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in  = {q_r, {(2 * dihed_pkg::ROOT_EXTRA){1'b0}}};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
    end

    assign delta    = ((DW+1)'(root_in) << (B + 1)) + ((DW+1)'(1) << (2 * B));
    assign ge       = (DW+1)'(rem_in) >= delta;
    assign rem_nxt  = ge ? (rem_in - delta[DW-1:0]) : rem_in;
    assign root_nxt = ge ? (root_in | (RB'(1) << B)) : root_in;

    always_ff @(posedge clk) begin
      sq_rem_r[j]  <= rem_nxt;
      sq_root_r[j] <= root_nxt;
    end
  end

  // ------------------------------------------------------ sine product, P1
  logic signed [L1:0]    s_alo;
  logic signed [XA-1:0]  s_ahi;
  logic signed [L2:0]    s_blo;
  logic signed [XB:0]    s_bhi;
  logic signed [MPW-1:0] m_ll_nxt, m_lh_nxt, m_hl_nxt, m_hh_nxt;
  logic signed [MPW-1:0] m_ll_r, m_lh_r, m_hl_r, m_hh_r;
  logic signed [D2W-1:0] pc_r;

  assign s_alo    = $signed({1'b0, dot1_dly_r[DLY-1][L1-1:0]});
  assign s_ahi    = $signed(dot1_dly_r[DLY-1][D1W-1:L1]);
  assign s_blo    = $signed({1'b0, sq_root_r[RB-1][L2-1:0]});
  assign s_bhi    = $signed({1'b0, sq_root_r[RB-1][RB-1:L2]});
  assign m_ll_nxt = s_alo * s_blo;
  assign m_lh_nxt = s_alo * s_bhi;
  assign m_hl_nxt = s_ahi * s_blo;
  assign m_hh_nxt = s_ahi * s_bhi;

  always_ff @(posedge clk) begin
    m_ll_r <= m_ll_nxt;
    m_lh_r <= m_lh_nxt;
    m_hl_r <= m_hl_nxt;
    m_hh_r <= m_hh_nxt;
    pc_r   <= dot2_dly_r[DLY-1];
  end

  // ------------------------------------------------- sine and cosine, P2
  logic signed [WW-1:0] s_nxt, s_r, c_nxt, c_r;

  assign s_nxt = (WW'(m_hh_r) <<< (L1 + L2)) + (WW'(m_hl_r) <<< L1)
               + (WW'(m_lh_r) <<< L2) + WW'(m_ll_r);
  assign c_nxt = WW'(pc_r) <<< dihed_pkg::ROOT_EXTRA;

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    c_r <= c_nxt;
  end

  // ---------------------------------------------------------- normalization
  logic signed [WW-1:0] ns_r [LVL], nc_r [LVL];

  // shift both right by 2^k while the larger magnitude still exceeds the limit
  for (genvar m = 0; m < LVL; m++) begin : g_norm
    localparam int SHK = 2 ** (LVL - 1 - m);
    localparam int TH  = dihed_pkg::NORM_BITS - 1 + SHK;
    logic signed [WW-1:0] s_in, c_in, s_out, c_out;

    if (m == 0) begin : g_first
      assign s_in = s_r;
      assign c_in = c_r;
    end else begin : g_next
      assign s_in = ns_r[m-1];
      assign c_in = nc_r[m-1];
    end

    if (TH < WW) begin : g_shift
      logic [WW-1:0] mag;
      logic          big;
      assign mag   = (s_in ^ {WW{s_in[WW-1]}}) | (c_in ^ {WW{c_in[WW-1]}});
      assign big   = |mag[WW-1:TH];
      assign s_out = big ? (s_in >>> SHK) : s_in;
      assign c_out = big ? (c_in >>> SHK) : c_in;
    end else begin : g_keep
      assign s_out = s_in;
      assign c_out = c_in;
    end

    always_ff @(posedge clk) begin
      ns_r[m] <= s_out;
      nc_r[m] <= c_out;
    end
  end

  // ------------------------------------------------------------ cordic
  logic signed [XW-1:0] cx_r [NSTEP+1], cy_r [NSTEP+1];
  logic signed [ZW-1:0] cz_r [NSTEP+1];
  logic                 yz_r [NSTEP+1], xn_r [NSTEP+1];
  logic signed [XW-1:0] x0, y0, cx0_nxt, cy0_nxt;
  logic signed [ZW-1:0] cz0_nxt;

  // pre-rotation into the right half plane
  assign x0      = XW'($signed(nc_r[LVL-1][dihed_pkg::NORM_BITS:0]));
  assign y0      = XW'($signed(ns_r[LVL-1][dihed_pkg::NORM_BITS:0]));
  assign cx0_nxt = x0[XW-1] ? -x0 : x0;
  assign cy0_nxt = x0[XW-1] ? -y0 : y0;
  assign cz0_nxt = !x0[XW-1] ? '0 : (y0[XW-1] ? -Z180 : Z180);

  always_ff @(posedge clk) begin
    cx_r[0] <= cx0_nxt;
    cy_r[0] <= cy0_nxt;
    cz_r[0] <= cz0_nxt;
    yz_r[0] <= (y0 == '0);
    xn_r[0] <= x0[XW-1];
  end

  // vectoring iterations, one per stage
  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] t, z_nxt;

    assign xs    = cx_r[i] >>> i;
    assign ys    = cy_r[i] >>> i;
    assign t     = $signed(ZW'(dihed_pkg::ATAN_TAB[i]));
    assign x_nxt = cy_r[i][XW-1] ? (cx_r[i] - ys) : (cx_r[i] + ys);
    assign y_nxt = cy_r[i][XW-1] ? (cy_r[i] + xs) : (cy_r[i] - xs);
    assign z_nxt = cy_r[i][XW-1] ? (cz_r[i] - t) : (cz_r[i] + t);

    always_ff @(posedge clk) begin
      cx_r[i+1] <= x_nxt;
      cy_r[i+1] <= y_nxt;
      cz_r[i+1] <= z_nxt;
      yz_r[i+1] <= yz_r[i];
      xn_r[i+1] <= xn_r[i];
    end
  end

  // ------------------------------------------------ rounding and clamping
  logic signed [ZW-1:0] zr, zc;
  logic signed [OW-1:0] res_nxt, res_r;

  always_comb begin
    zr = (cz_r[NSTEP] + ZHALF) >>> RSH;
    zc = zr;
    if (zr > LIM_Z) begin
      zc = LIM_Z;
    end else if (zr < -LIM_Z) begin
      zc = -LIM_Z;
    end
    // zero sine after normalization: on the x axis
    if (yz_r[NSTEP]) begin
      res_nxt = xn_r[NSTEP] ? LIM_O : '0;
    end else begin
      res_nxt = OW'(zc);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_torsion_deg = dihed_pkg::TORSION_W'(res_r);

  // ------------------------------------------------------------ assertions
  `DIHED_ASSERT_SAME(a_root_floor, vld_r[RB+1],
    (DW+1)'(sq_rem_r[RB-1]) <= ((DW+1)'(sq_root_r[RB-1]) << 1),
    "square root remainder exceeds floor bound")
  `DIHED_ASSERT_SAME(a_norm_fit, vld_r[RB+LVL+3],
    ((ns_r[LVL-1][WW-1:dihed_pkg::NORM_BITS] == '0) ||
     (ns_r[LVL-1][WW-1:dihed_pkg::NORM_BITS] == '1)) &&
    ((nc_r[LVL-1][WW-1:dihed_pkg::NORM_BITS] == '0) ||
     (nc_r[LVL-1][WW-1:dihed_pkg::NORM_BITS] == '1)),
    "normalized sine or cosine out of range")
  `DIHED_ASSERT_NEXT(a_out_range, vld_r[LAT-2],
    (res_r <= LIM_O) && (res_r >= -LIM_O),
    "angle outside half turn")

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for dihedral_angle_four_points_unit: random and directed
// point sets, bit-exact torsion predictor, queue-fed driver and clocked monitor
// depends on dihed_pkg and the dihedral_angle_four_points_unit rtl
`timescale 1ns / 1ps
module testbench;

  localparam int CW          = 20;
  localparam int FRAC        = 7;
  localparam int STEPS       = 16;
  localparam int NUM_RANDOM  = 1780;
  localparam int LATENCY     = 66;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TW          = dihed_pkg::TORSION_W;
  localparam int DFRAC       = dihed_pkg::DEG_FRAC;
  localparam int HALF_TURN   = dihed_pkg::HALF_TURN_DEG;

  typedef struct {
    logic [CW-1:0] c [12];
    bit            drain_first;
  } point_set_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [CW-1:0] coord [12];
  logic out_valid;
  logic signed [TW-1:0] out_torsion_deg;

  point_set_t pending_sets [$];
  logic [TW-1:0] expected_angles [$];
  int error_count;
  int sent_count;
  int checked_count;
  int zero_count;
  int cycle_count;

  dihedral_angle_four_points_unit #(
    .COORD_WIDTH(CW), .ANGLE_FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_p1_x(coord[0]), .in_p1_y(coord[1]), .in_p1_z(coord[2]),
    .in_p2_x(coord[3]), .in_p2_y(coord[4]), .in_p2_z(coord[5]),
    .in_p3_x(coord[6]), .in_p3_y(coord[7]), .in_p3_z(coord[8]),
    .in_p4_x(coord[9]), .in_p4_y(coord[10]), .in_p4_z(coord[11]),
    .out_valid(out_valid), .out_torsion_deg(out_torsion_deg)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cordic vectoring on normalized sine and cosine
  function automatic longint cordic_degrees(longint x_in, longint y_in);
    longint x, y, z, xs, ys, res, lim;
    int s;
    x = x_in;
    y = y_in;
    z = 0;
    s = DFRAC - FRAC;
    if (y == 0) begin
      z = (x >= 0) ? 0 : (longint'(HALF_TURN) <<< DFRAC);
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? (longint'(HALF_TURN) <<< DFRAC)
                     : -(longint'(HALF_TURN) <<< DFRAC);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS && i < dihed_pkg::ATAN_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + longint'(dihed_pkg::ATAN_TAB[i]);
        end else begin
          x = x - ys; y = y + xs; z = z - longint'(dihed_pkg::ATAN_TAB[i]);
        end
      end
    end
    // round half up, then clamp to a half turn
    res = ((z + (longint'(256) <<< DFRAC) + (longint'(1) <<< (s - 1))) >>> s)
          - (longint'(256) <<< FRAC);
    lim = longint'(HALF_TURN) <<< FRAC;
    if (res > lim) res = lim;
    if (res < -lim) res = -lim;
    return res;
  endfunction

  // magnitude length of a wide two's complement value
  function automatic int mag_length(logic signed [191:0] v);
    logic [191:0] m;
    m = v[191] ? ~v : v;
    for (int b = 191; b >= 0; b--)
      if (m[b]) return b + 1;
    return 0;
  endfunction

  // torsion angle of one point set, exact wide arithmetic
  function automatic logic [TW-1:0] torsion_of(point_set_t ps);
    logic signed [191:0] p [4][3];
    logic signed [191:0] r1 [3], r2 [3], r3 [3], n1 [3], n2 [3];
    logic signed [191:0] sw, cw;
    logic [191:0] len_sq, tt;
    logic [63:0] root, t;
    longint x, y, res;
    int len, sh;
    for (int k = 0; k < 4; k++)
      for (int c = 0; c < 3; c++)
        p[k][c] = $signed(ps.c[k*3+c]);
    for (int c = 0; c < 3; c++) begin
      r1[c] = p[1][c] - p[0][c];
      r2[c] = p[2][c] - p[1][c];
      r3[c] = p[3][c] - p[2][c];
    end
    n1[0] = r1[1]*r2[2] - r1[2]*r2[1];
    n1[1] = r1[2]*r2[0] - r1[0]*r2[2];
    n1[2] = r1[0]*r2[1] - r1[1]*r2[0];
    n2[0] = r2[1]*r3[2] - r2[2]*r3[1];
    n2[1] = r2[2]*r3[0] - r2[0]*r3[2];
    n2[2] = r2[0]*r3[1] - r2[1]*r3[0];
    len_sq = (r2[0]*r2[0] + r2[1]*r2[1] + r2[2]*r2[2]) << (2*dihed_pkg::ROOT_EXTRA);
    // bit-serial floor square root
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      t = root | (64'd1 << b);
      tt = {128'd0, t} * {128'd0, t};
      if (tt <= len_sq) root = t;
    end
    sw = (n1[0]*r3[0] + n1[1]*r3[1] + n1[2]*r3[2]) * $signed({128'd0, root});
    cw = (n1[0]*n2[0] + n1[1]*n2[1] + n1[2]*n2[2]) <<< dihed_pkg::ROOT_EXTRA;
    if (sw == 0 && cw == 0) return '0;
    len = mag_length(sw);
    if (mag_length(cw) > len) len = mag_length(cw);
    sh = (len > dihed_pkg::NORM_BITS) ? len - dihed_pkg::NORM_BITS : 0;
    sw = sw >>> sh;
    cw = cw >>> sh;
    y = longint'($signed(sw[31:0]));
    x = longint'($signed(cw[31:0]));
    res = cordic_degrees(x, y);
    return res[TW-1:0];
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  // point set from twelve values
  function automatic point_set_t make_set(int v [12]);
    point_set_t ps;
    for (int i = 0; i < 12; i++) ps.c[i] = CW'(v[i]);
    ps.drain_first = 1'b0;
    return ps;
  endfunction

  // driver: bursts with random gaps, optional drain before an item
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    point_set_t cur;
    point_set_t nxt;
    bit give;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      for (int i = 0; i < 12; i++) coord[i] <= '0;
    end else begin
      if (start && !busy) begin
        for (int i = 0; i < 12; i++) cur.c[i] = coord[i];
        expected_angles.push_back(torsion_of(cur));
        sent_count <= sent_count + 1;
        void'(pending_sets.pop_front());
      end
      give = 1'b0;
      if (start && busy) begin
        give = 1'b1;
      end else if (pending_sets.size() > 0) begin
        nxt = pending_sets[0];
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (nxt.drain_first && expected_angles.size() > 0) begin
          give = 1'b0;
        end else begin
          give = 1'b1;
          for (int i = 0; i < 12; i++) coord[i] <= nxt.c[i];
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      start <= give;
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    logic [TW-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d",
                 $time, out_torsion_deg);
        error_count <= error_count + 1;
      end else begin
        want = expected_angles.pop_front();
        if (want !== out_torsion_deg) begin
          $display("%0t: torsion_deg expected %0d actual %0d",
                   $time, $signed(want), out_torsion_deg);
          error_count <= error_count + 1;
        end
        if (want == 0) zero_count <= zero_count + 1;
        checked_count <= checked_count + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    int v [12];
    int base;
    int spread;
    int kind;
    point_set_t ps;
    rst_n = 1'b0;

    // directed: all zero, both extremes, alternating extremes
    v = '{default: 0};
    pending_sets.push_back(make_set(v));
    v = '{default: 524287};
    pending_sets.push_back(make_set(v));
    v = '{default: -524288};
    pending_sets.push_back(make_set(v));
    for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 524287 : -524288;
    pending_sets.push_back(make_set(v));
    for (int i = 0; i < 12; i++) v[i] = (i % 3 == 1) ? -524288 : 524287;
    pending_sets.push_back(make_set(v));
    for (int i = 0; i < 12; i++) v[i] = ((i / 3) % 2) ? -524288 : 524287;
    pending_sets.push_back(make_set(v));
    // trans (180), cis (0), +90 and -90 with bonds of length 1024
    v = '{0, 1024, 0,  0, 0, 0,  1024, 0, 0,  1024, -1024, 0};
    pending_sets.push_back(make_set(v));
    v = '{0, 1024, 0,  0, 0, 0,  1024, 0, 0,  1024, 1024, 0};
    pending_sets.push_back(make_set(v));
    v = '{0, 1024, 0,  0, 0, 0,  1024, 0, 0,  1024, 0, 1024};
    pending_sets.push_back(make_set(v));
    v = '{0, 1024, 0,  0, 0, 0,  1024, 0, 0,  1024, 0, -1024};
    pending_sets.push_back(make_set(v));
    // collinear points, coincident middle points
    v = '{0, 0, 0,  100, 200, 300,  200, 400, 600,  300, 600, 900};
    pending_sets.push_back(make_set(v));
    v = '{5, 7, 9,  1, 1, 1,  1, 1, 1,  8, -3, 2};
    pending_sets.push_back(make_set(v));
    // sine exactly zero with negative cosine, tiny values
    v = '{0, 1, 0,  0, 0, 0,  1, 0, 0,  1, -1, 0};
    pending_sets.push_back(make_set(v));
    v = '{0, 1, 0,  0, 0, 0,  1, 0, 0,  1, 1, 1};
    pending_sets.push_back(make_set(v));
    // extreme long bond, near-planar
    v = '{-524288, 524287, 0,  -524288, -524288, 0,  524287, -524288, 0,
          524287, 524287, 1};
    pending_sets.push_back(make_set(v));
    v = '{524287, 0, -524288,  -524288, 0, -524288,  -524288, 0, 524287,
          524287, -1, 524287};
    pending_sets.push_back(make_set(v));

    // random: full range, local clusters and degenerate geometry
    for (int n = 0; n < NUM_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        for (int i = 0; i < 12; i++) ps.c[i] = rand_coord();
      end else if (kind < 8) begin
        spread = 1 << $urandom_range(1, 17);
        for (int i = 0; i < 12; i++) begin
          base = (i < 3) ? $urandom_range(0, 2*262143) - 262143 : v[i-3];
          v[i] = base + $urandom_range(0, 2*spread) - spread;
          if (v[i] > 524287) v[i] = 524287;
          if (v[i] < -524288) v[i] = -524288;
          ps.c[i] = CW'(v[i]);
        end
      end else if (kind == 8) begin
        // collinear along a random direction
        for (int i = 0; i < 3; i++) begin
          v[i] = $urandom_range(0, 2000) - 1000;
          v[i+3] = $urandom_range(0, 200) - 100;
        end
        for (int k = 0; k < 4; k++)
          for (int i = 0; i < 3; i++) ps.c[k*3+i] = CW'(v[i] + k * v[i+3]);
      end else begin
        // repeated point somewhere in the chain
        for (int i = 0; i < 12; i++) ps.c[i] = rand_coord();
        base = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) ps.c[(base+1)*3+i] = ps.c[base*3+i];
      end
      ps.drain_first = ($urandom_range(0, 299) == 0) || (n == NUM_RANDOM / 2);
      pending_sets.push_back(ps);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all transactions and results, then let the pipeline settle
    while (pending_sets.size() != 0 || expected_angles.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d point sets, checked %0d torsion results (%0d zero angles)",
             sent_count, checked_count, zero_count);
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/dihed_pkg.sv
hw/rtl/dihedral_angle_four_points_unit.sv
tb/sv/testbench.sv
